// ===== hdl/nmea_rmc_fix_parser_assert.svh =====
// Assertion macros shared by the parser's checking code.
`ifndef NMEA_RMC_FIX_PARSER_ASSERT_SVH
`define NMEA_RMC_FIX_PARSER_ASSERT_SVH

// The condition must never be true at a clock edge outside reset.
`define NRMC_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("nrmc: forbidden condition seen");

// When the first condition holds, the second holds in the next cycle.
`define NRMC_THEN_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("nrmc: expected follow-up missing");

`endif

// ===== hdl/nrmc_pkg.sv =====
package nrmc_pkg;

  // Characters the parser recognises.
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SOUTH = 8'h53;
  localparam logic [7:0] CH_WEST  = 8'h57;

  // Field numbers within the sentence (commas counted before the field ends).
  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;
  localparam logic [3:0] FLD_SPEED  = 4'd7;
  localparam logic [3:0] FLD_COURSE = 4'd8;

  // Saturation limits and scale factors.
  localparam logic [39:0] ACC_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [32:0] LAT_MAX = 33'h0_3FFF_FFFF;
  localparam logic [32:0] LON_MAX = 33'h0_7FFF_FFFF;
  localparam logic [31:0] E7      = 32'd10000000;
  // Smallest scaled knot value whose km/h figure no longer fits 28 bits.
  localparam logic [59:0] SPD_LIM = 60'd144943551;

  localparam int Q_DEPTH = 4;

  // One finished field handed from the character front end to the converter.
  typedef struct packed {
    logic [39:0] acc;
    logic [2:0]  frac;
    logic        minus;
    logic [7:0]  first;
    logic [3:0]  fidx;
    logic        emit;
    logic [3:0]  seen;
  } rec_t;

  // Power of ten evaluated at elaboration.
  function automatic longint unsigned pow10_c(input int n);
    longint unsigned v;
    v = 1;
    for (int i = 0; i < n; i++) v = v * 10;
    return v;
  endfunction

  // Power of ten for run-time padding of missing fraction digits.
  function automatic logic [19:0] pow10_lut(input logic [2:0] n);
    logic [19:0] v;
    unique case (n)
      3'd0: v = 20'd1;
      3'd1: v = 20'd10;
      3'd2: v = 20'd100;
      3'd3: v = 20'd1000;
      3'd4: v = 20'd10000;
      3'd5: v = 20'd100000;
      3'd6: v = 20'd1000000;
      default: v = 20'd1;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/nrmc_fifo.sv =====
module nrmc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  nrmc_pkg::rec_t  wr_data,
  input  logic            pop,
  output nrmc_pkg::rec_t  rd_data,
  output logic            full,
  output logic            empty
);
  import nrmc_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  rec_t          mem_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign full    = (count_r == (PW+1)'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== hdl/nrmc_front.sv =====
module nrmc_front #(
  parameter int FRACTION_DIGITS = 4,
  parameter int MAX_FIELD_CHARS = 15
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     ch,
  input  logic           eos,
  output logic           push,
  output nrmc_pkg::rec_t rec
);
  import nrmc_pkg::*;

  logic [3:0]  comma_r, comma_nxt;
  logic [39:0] acc_r, acc_nxt;
  logic [2:0]  frac_r, frac_nxt;
  logic        pnt_r, pnt_nxt;
  logic        minus_r, minus_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [3:0]  chars_r, chars_nxt;
  logic        stop_r, stop_nxt;
  logic        done_r, done_nxt;

  // Field state after taking the current character.
  logic [39:0] f_acc;
  logic [2:0]  f_frac;
  logic        f_pnt, f_minus, f_stop;
  logic [7:0]  f_first;
  logic [3:0]  f_chars;
  logic        is_digit;
  logic [43:0] t10;
  logic [39:0] t10_sat;

  // Character feed: digit accumulation, point, sign and stop conditions.
  always_comb begin
    f_acc    = acc_r;
    f_frac   = frac_r;
    f_pnt    = pnt_r;
    f_minus  = minus_r;
    f_stop   = stop_r;
    f_first  = first_r;
    f_chars  = chars_r;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    t10      = 44'(acc_r) * 44'd10 + 44'(ch - CH_ZERO);
    t10_sat  = (t10 > 44'(ACC_MAX)) ? ACC_MAX : t10[39:0];
    if (chars_r < 4'(MAX_FIELD_CHARS)) begin
      f_first = (chars_r == '0) ? ch : first_r;
      f_chars = chars_r + 1'b1;
      if (!stop_r) begin
        if (is_digit) begin
          if (!pnt_r) begin
            f_acc = t10_sat;
          end else if (frac_r < 3'(FRACTION_DIGITS)) begin
            f_acc  = t10_sat;
            f_frac = frac_r + 1'b1;
          end
        end else if (ch == CH_POINT && !pnt_r) begin
          f_pnt = 1'b1;
        end else if ((ch == CH_MINUS || ch == CH_PLUS) && chars_r == '0) begin
          f_minus = (ch == CH_MINUS);
        end else begin
          f_stop = 1'b1;
        end
      end
    end
  end

  // Sentence sequencing: field ends, result requests and clearing.
  always_comb begin
    comma_nxt = comma_r;
    acc_nxt   = acc_r;
    frac_nxt  = frac_r;
    pnt_nxt   = pnt_r;
    minus_nxt = minus_r;
    first_nxt = first_r;
    chars_nxt = chars_r;
    stop_nxt  = stop_r;
    done_nxt  = done_r;
    push      = 1'b0;
    rec       = '0;
    if (accept) begin
      priority if (done_r) begin
        // The end marker after the ninth comma starts a fresh sentence.
        if (eos) begin
          done_nxt  = 1'b0;
          comma_nxt = '0;
        end
      end else if (ch == CH_COMMA) begin
        push       = 1'b1;
        rec.acc    = acc_r;
        rec.frac   = frac_r;
        rec.minus  = minus_r;
        rec.first  = first_r;
        rec.fidx   = comma_r;
        rec.emit   = eos || (comma_r == FLD_COURSE);
        rec.seen   = comma_r + 1'b1;
        acc_nxt    = '0;
        frac_nxt   = '0;
        pnt_nxt    = 1'b0;
        minus_nxt  = 1'b0;
        first_nxt  = '0;
        chars_nxt  = '0;
        stop_nxt   = 1'b0;
        if (eos) begin
          comma_nxt = '0;
        end else begin
          comma_nxt = comma_r + 1'b1;
          done_nxt  = (comma_r == FLD_COURSE);
        end
      end else if (eos) begin
        push       = 1'b1;
        rec.acc    = f_acc;
        rec.frac   = f_frac;
        rec.minus  = f_minus;
        rec.first  = f_first;
        rec.fidx   = comma_r;
        rec.emit   = 1'b1;
        rec.seen   = comma_r;
        comma_nxt  = '0;
        acc_nxt    = '0;
        frac_nxt   = '0;
        pnt_nxt    = 1'b0;
        minus_nxt  = 1'b0;
        first_nxt  = '0;
        chars_nxt  = '0;
        stop_nxt   = 1'b0;
      end else begin
        acc_nxt   = f_acc;
        frac_nxt  = f_frac;
        pnt_nxt   = f_pnt;
        minus_nxt = f_minus;
        first_nxt = f_first;
        chars_nxt = f_chars;
        stop_nxt  = f_stop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comma_r <= '0;
      acc_r   <= '0;
      frac_r  <= '0;
      pnt_r   <= 1'b0;
      minus_r <= 1'b0;
      first_r <= '0;
      chars_r <= '0;
      stop_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      comma_r <= comma_nxt;
      acc_r   <= acc_nxt;
      frac_r  <= frac_nxt;
      pnt_r   <= pnt_nxt;
      minus_r <= minus_nxt;
      first_r <= first_nxt;
      chars_r <= chars_nxt;
      stop_r  <= stop_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

// ===== hdl/nrmc_cdiv.sv =====
// Division by a constant: reciprocal multiply, then one correction step.
// Three register stages, advancing together when en is high.
module nrmc_cdiv #(
  parameter int              XW  = 30,
  parameter longint unsigned DIV = 60,
  parameter int              QW  = 24,
  parameter int              RW  = 6
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x,
  output logic [QW-1:0] q,
  output logic [RW-1:0] r
);

  localparam longint unsigned M  = (64'd1 << XW) / DIV;
  localparam int              MW = $clog2(M + 1);
  localparam logic [XW-1:0]   DIV_V = XW'(DIV);
  localparam logic [MW-1:0]   M_V   = MW'(M);

  logic [XW+MW-1:0] p_r;
  logic [XW-1:0]    x1_r, x2_r, qd_r;
  logic [MW-1:0]    q0_r;
  logic [MW-1:0]    q_est;
  logic [XW-1:0]    r0;
  logic             over;

  assign q_est = p_r[XW+MW-1:XW];
  assign r0    = x2_r - qd_r;
  assign over  = (r0 >= DIV_V);

  // Estimate is exact or one too small; the remainder check fixes it.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r  <= (XW+MW)'(x) * (XW+MW)'(M_V);
      x1_r <= x;
      q0_r <= q_est;
      qd_r <= XW'(XW'(q_est) * DIV_V);
      x2_r <= x1_r;
      q    <= over ? QW'(q0_r + 1'b1) : QW'(q0_r);
      r    <= over ? RW'(r0 - DIV_V) : RW'(r0);
    end
  end

endmodule

// ===== hdl/nrmc_back.sv =====
module nrmc_back #(
  parameter int FRACTION_DIGITS = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  nrmc_pkg::rec_t rec,
  input  logic           rec_valid,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_utc,
  output logic [7:0]     out_status,
  output logic [30:0]    out_lat,
  output logic [31:0]    out_lon,
  output logic [27:0]    out_speed,
  output logic [21:0]    out_course,
  output logic [3:0]     out_seen
);
  import nrmc_pkg::*;

  localparam longint unsigned UNIT   = pow10_c(FRACTION_DIGITS);
  localparam longint unsigned D_DEG  = 100 * UNIT;
  localparam longint unsigned DM_LIM = 215 * D_DEG;
  localparam int              DM_W   = $clog2(DM_LIM);
  localparam int              DR_W   = $clog2(D_DEG);
  localparam logic [59:0]     DM_LIM_V  = 60'(DM_LIM);
  localparam logic [59:0]     CRS_MAX_V = 60'(360 * UNIT);
  localparam logic [29:0]     MM_K   = 30'(pow10_c(7 - FRACTION_DIGITS));
  localparam int              NSTG   = 10;

  typedef struct packed {
    logic [3:0]  fidx;
    logic        emit;
    logic [3:0]  seen;
    logic [7:0]  first;
    logic        neg;
    logic [31:0] tim;
    logic [21:0] crs;
    logic        dm_big;
    logic        spd_big;
    logic [27:0] xs;
    logic [31:0] deg_e7;
    logic [27:0] spd;
    logic [32:0] re7;
  } side_t;

  logic             adv;
  logic [NSTG:1]    vld_r;
  side_t            side_r [1:NSTG];
  side_t            side_in;
  side_t            stg2, stg6, stg10;
  logic [59:0]      prod_r;
  logic [DM_W-1:0]  xdm_r;
  logic [35:0]      ps213_r;
  logic [29:0]      mm_r;
  logic [7:0]       deg_q;
  logic [DR_W-1:0]  minu_q;
  logic [27:0]      spd_q;
  logic [23:0]      min_q;

  // Held results of the sentence in progress.
  logic [31:0] h_time_r, h_time_nxt;
  logic [7:0]  h_stat_r, h_stat_nxt;
  logic [30:0] h_lat_r, h_lat_nxt;
  logic [31:0] h_lon_r, h_lon_nxt;
  logic [27:0] h_spd_r, h_spd_nxt;
  logic [21:0] h_crs_r, h_crs_nxt;
  logic        commit;
  logic [30:0] lat_mag;
  logic [31:0] lon_mag;

  // The whole converter moves in step, held only by a waiting result.
  assign adv = !out_valid || out_ready;
  assign pop = adv && rec_valid;

  always_comb begin
    side_in       = '0;
    side_in.fidx  = rec.fidx;
    side_in.emit  = rec.emit;
    side_in.seen  = rec.seen;
    side_in.first = rec.first;
    side_in.neg   = rec.minus && (|rec.acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-1:1], rec_valid};
    end
  end

  // Stage 2 classifies the value; stage 6 forms degrees and speed;
  // stage 10 sums the degrees.
  always_comb begin
    stg2         = side_r[1];
    stg2.tim     = side_r[1].neg ? 32'd0 :
                   (prod_r > 60'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod_r[31:0];
    stg2.crs     = (side_r[1].neg || prod_r > CRS_MAX_V) ? 22'd0 : prod_r[21:0];
    stg2.dm_big  = (prod_r >= DM_LIM_V);
    stg2.spd_big = (prod_r >= SPD_LIM);
    stg2.xs      = prod_r[27:0];

    stg6         = side_r[5];
    stg6.deg_e7  = 32'(32'(deg_q) * E7);
    stg6.spd     = side_r[5].xs + spd_q;

    stg10        = side_r[9];
    stg10.re7    = 33'(side_r[9].deg_e7) + 33'(min_q);
  end

  // Stage 1 pads missing fraction digits; the rest shift along.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r     <= 60'(rec.acc) * 60'(pow10_lut(3'(FRACTION_DIGITS) - rec.frac));
      side_r[1]  <= side_in;
      side_r[2]  <= stg2;
      for (int k = 3; k <= 5; k++) side_r[k] <= side_r[k-1];
      side_r[6]  <= stg6;
      for (int k = 7; k <= 9; k++) side_r[k] <= side_r[k-1];
      side_r[10] <= stg10;
      xdm_r      <= prod_r[DM_W-1:0];
      ps213_r    <= 36'(prod_r[27:0]) * 36'd213;
      mm_r       <= 30'(30'(minu_q) * MM_K);
    end
  end

  // Whole degrees and leftover minutes.
  nrmc_cdiv #(.XW(DM_W), .DIV(D_DEG), .QW(8), .RW(DR_W)) u_div_deg (
    .clk(clk), .en(adv), .x(xdm_r), .q(deg_q), .r(minu_q)
  );

  // Speed: knots * 213 / 250 as (value / 2) / 125.
  nrmc_cdiv #(.XW(35), .DIV(125), .QW(28), .RW(7)) u_div_spd (
    .clk(clk), .en(adv), .x(ps213_r[35:1]), .q(spd_q), .r()
  );

  // Minutes to 1e-7 degrees.
  nrmc_cdiv #(.XW(30), .DIV(60), .QW(24), .RW(6)) u_div_min (
    .clk(clk), .en(adv), .x(mm_r), .q(min_q), .r()
  );

  assign lat_mag = (side_r[NSTG].dm_big || side_r[NSTG].re7 > LAT_MAX) ?
                   31'(LAT_MAX) : side_r[NSTG].re7[30:0];
  assign lon_mag = (side_r[NSTG].dm_big || side_r[NSTG].re7 > LON_MAX) ?
                   32'(LON_MAX) : side_r[NSTG].re7[31:0];
  assign commit  = adv && vld_r[NSTG];

  // Apply the finished field to the held results.
  always_comb begin
    h_time_nxt = h_time_r;
    h_stat_nxt = h_stat_r;
    h_lat_nxt  = h_lat_r;
    h_lon_nxt  = h_lon_r;
    h_spd_nxt  = h_spd_r;
    h_crs_nxt  = h_crs_r;
    unique case (side_r[NSTG].fidx)
      FLD_TIME:   h_time_nxt = side_r[NSTG].tim;
      FLD_STATUS: h_stat_nxt = side_r[NSTG].first;
      FLD_LAT:    h_lat_nxt  = side_r[NSTG].neg ? 31'd0 - lat_mag : lat_mag;
      FLD_NS:     if (side_r[NSTG].first == CH_SOUTH) h_lat_nxt = 31'd0 - h_lat_r;
      FLD_LON:    h_lon_nxt  = side_r[NSTG].neg ? 32'd0 - lon_mag : lon_mag;
      FLD_EW:     if (side_r[NSTG].first == CH_WEST) h_lon_nxt = 32'd0 - h_lon_r;
      FLD_SPEED:  h_spd_nxt  = side_r[NSTG].neg ? 28'd0 :
                               side_r[NSTG].spd_big ? 28'hFFF_FFFF : side_r[NSTG].spd;
      FLD_COURSE: h_crs_nxt  = side_r[NSTG].crs;
      default: ;
    endcase
  end

  // Held results clear whenever a sentence's result goes out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_time_r <= '0;
      h_stat_r <= '0;
      h_lat_r  <= '0;
      h_lon_r  <= '0;
      h_spd_r  <= '0;
      h_crs_r  <= '0;
    end else if (commit) begin
      if (side_r[NSTG].emit) begin
        h_time_r <= '0;
        h_stat_r <= '0;
        h_lat_r  <= '0;
        h_lon_r  <= '0;
        h_spd_r  <= '0;
        h_crs_r  <= '0;
      end else begin
        h_time_r <= h_time_nxt;
        h_stat_r <= h_stat_nxt;
        h_lat_r  <= h_lat_nxt;
        h_lon_r  <= h_lon_nxt;
        h_spd_r  <= h_spd_nxt;
        h_crs_r  <= h_crs_nxt;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (commit && side_r[NSTG].emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && side_r[NSTG].emit) begin
      out_utc    <= h_time_nxt;
      out_status <= h_stat_nxt;
      out_lat    <= h_lat_nxt;
      out_lon    <= h_lon_nxt;
      out_speed  <= h_spd_nxt;
      out_course <= h_crs_nxt;
      out_seen   <= side_r[NSTG].seen;
    end
  end

endmodule

// ===== hdl/nmea_rmc_fix_parser.sv =====
// RMC sentence parser: takes one character per cycle whenever the field queue
// has room, so a sentence streams in at one byte per clock. Up to the ninth
// comma, each comma or the end-of-sentence byte hands one field record to a
// four-entry queue; a converter pipeline of ten stages (two of its three
// constant-divider units, of three stages each, lie in series and set its
// length) turns fields into degrees, km/h and scaled time, taking one field per
// cycle unless a result waits unread. A result waits in an output register;
// the input stalls only when the queue is full.
module nmea_rmc_fix_parser #(
  parameter int FRACTION_DIGITS = 4,
  parameter int MAX_FIELD_CHARS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_byte,
  input  logic               in_end_of_sentence,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_utc_time_scaled,
  output logic [7:0]         out_fix_status,
  output logic signed [30:0] out_latitude_e7,
  output logic signed [31:0] out_longitude_e7,
  output logic [27:0]        out_speed_kmh_scaled,
  output logic [21:0]        out_course_scaled,
  output logic [3:0]         out_fields_seen
);
  import nrmc_pkg::*;

  logic        accept, push, pop, q_full, q_empty;
  rec_t        push_rec, head_rec;
  logic [30:0] lat_w;
  logic [31:0] lon_w;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  nrmc_front #(
    .FRACTION_DIGITS(FRACTION_DIGITS),
    .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept), .ch(in_char_byte),
    .eos(in_end_of_sentence), .push(push), .rec(push_rec)
  );

  nrmc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wr_data(push_rec), .pop(pop),
    .rd_data(head_rec), .full(q_full), .empty(q_empty)
  );

  nrmc_back #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_back (
    .clk(clk), .rst_n(rst_n), .rec(head_rec), .rec_valid(!q_empty), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_utc(out_utc_time_scaled),
    .out_status(out_fix_status), .out_lat(lat_w), .out_lon(lon_w),
    .out_speed(out_speed_kmh_scaled), .out_course(out_course_scaled),
    .out_seen(out_fields_seen)
  );

  assign out_latitude_e7  = $signed(lat_w);
  assign out_longitude_e7 = $signed(lon_w);

`include "nmea_rmc_fix_parser_assert.svh"

  `NRMC_NEVER(a_no_push_when_full, push && q_full)
  `NRMC_NEVER(a_no_pop_when_empty, pop && q_empty)
  `NRMC_NEVER(a_seen_in_range, out_valid && out_fields_seen > 4'd9)
  `NRMC_THEN_NEXT(a_push_fills, push && !pop && q_empty, !q_empty)

endmodule

// ===== test/tb_nmea_rmc_fix_parser.sv =====
`default_nettype none

module tb_nmea_rmc_fix_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import nrmc_pkg::*;

  localparam longint unsigned FIELD_MAX  = 64'hFF_FFFF_FFFF;
  localparam longint unsigned LAT_LIMIT  = 64'h3FFF_FFFF;
  localparam longint unsigned LON_LIMIT  = 64'h7FFF_FFFF;
  localparam longint unsigned DEG_E7     = 64'd10000000;
  localparam longint unsigned UNIT_SCALE = 64'd10000;
  localparam int              WATCHDOG_LIMIT = 20000;
  localparam int unsigned     MAX_FIELD_CHARS_TB = 15;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } rmc_byte_t;

  typedef struct packed {
    logic [31:0] utc;
    logic [7:0]  status;
    logic [30:0] lat;
    logic [31:0] lon;
    logic [27:0] speed;
    logic [21:0] course;
    logic [3:0]  seen;
  } rmc_fix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_char_byte = 8'h00;
  logic in_end_of_sentence = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_utc_time_scaled;
  logic [7:0] out_fix_status;
  logic signed [30:0] out_latitude_e7;
  logic signed [31:0] out_longitude_e7;
  logic [27:0] out_speed_kmh_scaled;
  logic [21:0] out_course_scaled;
  logic [3:0] out_fields_seen;

  nmea_rmc_fix_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_char_byte(in_char_byte), .in_end_of_sentence(in_end_of_sentence),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_utc_time_scaled(out_utc_time_scaled), .out_fix_status(out_fix_status),
    .out_latitude_e7(out_latitude_e7), .out_longitude_e7(out_longitude_e7),
    .out_speed_kmh_scaled(out_speed_kmh_scaled), .out_course_scaled(out_course_scaled),
    .out_fields_seen(out_fields_seen)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rmc_byte_t pending_bytes[$];
  rmc_fix_t  expected_fixes[$];
  int mismatches = 0;
  int fixes_checked = 0;
  int bytes_taken = 0;
  int sentences_built = 0;
  int idle_cycles = 0;
  logic byte_taken = 1'b0;

  // Shadow of the parser state.
  int unsigned     p_commas;
  longint unsigned p_acc;
  int unsigned     p_frac;
  bit              p_point, p_minus, p_stopped, p_done;
  logic [7:0]      p_first;
  int unsigned     p_chars;
  longint unsigned p_utc, p_status, p_lat, p_lon, p_speed, p_course;

  function automatic longint unsigned shift_digit(longint unsigned v, longint unsigned d);
    if (v > (FIELD_MAX - d) / 10) return FIELD_MAX;
    return v * 10 + d;
  endfunction

  // ddmm.mmmm in scaled units to a 1e-7 degree magnitude, saturated.
  function automatic longint unsigned degmin_to_e7(longint unsigned v, longint unsigned lim);
    longint unsigned deg, mins, r;
    deg  = v / (100 * UNIT_SCALE);
    mins = v - deg * 100 * UNIT_SCALE;
    r    = deg * DEG_E7 + (mins * DEG_E7) / (60 * UNIT_SCALE);
    return (r > lim) ? lim : r;
  endfunction

  function automatic void clear_field();
    p_acc = 0; p_frac = 0; p_point = 0; p_minus = 0;
    p_first = 8'h00; p_chars = 0; p_stopped = 0;
  endfunction

  function automatic void clear_sentence();
    clear_field();
    p_commas = 0; p_done = 0;
    p_utc = 0; p_status = 0; p_lat = 0; p_lon = 0; p_speed = 0; p_course = 0;
  endfunction

  function automatic void add_char(logic [7:0] c);
    if (p_chars >= MAX_FIELD_CHARS_TB) return;
    if (p_chars == 0) p_first = c;
    p_chars++;
    if (p_stopped) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (!p_point) begin
        p_acc = shift_digit(p_acc, c - CH_ZERO);
      end else if (p_frac < 4) begin
        p_acc = shift_digit(p_acc, c - CH_ZERO);
        p_frac++;
      end
    end else if (c == CH_POINT && !p_point) begin
      p_point = 1;
    end else if ((c == CH_MINUS || c == CH_PLUS) && p_chars == 1) begin
      p_minus = (c == CH_MINUS);
    end else begin
      p_stopped = 1;
    end
  endfunction

  // Converts the field that has just closed into its part of the fix.
  function automatic void close_field();
    longint unsigned v, s;
    bit neg;
    v = p_acc;
    neg = p_minus && (v != 0);
    for (int k = p_frac; k < 4; k++) v = shift_digit(v, 0);
    case (p_commas)
      FLD_TIME:   p_utc = neg ? 0 : ((v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v);
      FLD_STATUS: p_status = p_first;
      FLD_LAT: begin
        s = degmin_to_e7(v, LAT_LIMIT);
        p_lat = neg ? -s : s;
      end
      FLD_NS:     if (p_first == CH_SOUTH) p_lat = -p_lat;
      FLD_LON: begin
        s = degmin_to_e7(v, LON_LIMIT);
        p_lon = neg ? -s : s;
      end
      FLD_EW:     if (p_first == CH_WEST) p_lon = -p_lon;
      FLD_SPEED: begin
        s = neg ? 0 : (v * 1852) / 1000;
        p_speed = (s > 64'hFFF_FFFF) ? 64'hFFF_FFFF : s;
      end
      FLD_COURSE: p_course = (neg || v > 360 * UNIT_SCALE) ? 0 : v;
      default: ;
    endcase
  endfunction

  function automatic void queue_fix();
    rmc_fix_t f;
    f.utc = p_utc[31:0];
    f.status = p_status[7:0];
    f.lat = p_lat[30:0];
    f.lon = p_lon[31:0];
    f.speed = p_speed[27:0];
    f.course = p_course[21:0];
    f.seen = p_commas[3:0];
    expected_fixes.push_back(f);
  endfunction

  // Advances the shadow parser by one accepted character.
  function automatic void track_rmc_char(logic [7:0] c, logic eos);
    if (p_done) begin
      if (eos) clear_sentence();
      return;
    end
    if (c == CH_COMMA) begin
      close_field();
      p_commas++;
      clear_field();
      if (p_commas >= 9) begin
        queue_fix();
        if (eos) clear_sentence();
        else p_done = 1;
      end else if (eos) begin
        queue_fix();
        clear_sentence();
      end
      return;
    end
    add_char(c);
    if (eos) begin
      close_field();
      queue_fix();
      clear_sentence();
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_number(int ip, int fp);
    string s;
    s = rand_digits(ip);
    if ($urandom_range(0, 9) != 0) s = {s, ".", rand_digits(fp)};
    case ($urandom_range(0, 19))
      0: s = {"-", s};
      1: s = {"+", s};
      2: s = rand_digits($urandom_range(14, 20));
      3: s = "";
      default: ;
    endcase
    return s;
  endfunction

  function automatic void push_text(string s);
    rmc_byte_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.chr = s[i];
      b.last = (i == s.len() - 1);
      pending_bytes.push_back(b);
    end
  endfunction

  // Queues one byte as it is, including a zero byte that a string cannot hold.
  function automatic void push_raw(logic [7:0] c, logic last);
    rmc_byte_t b;
    b.chr = c;
    b.last = last;
    pending_bytes.push_back(b);
  endfunction

  function automatic string build_sentence();
    string s;
    string hemi_ns, hemi_ew, stat;
    hemi_ns = ($urandom_range(0, 2) == 0) ? "" : (($urandom_range(0, 1) != 0) ? "S" : "N");
    hemi_ew = ($urandom_range(0, 2) == 0) ? "" : (($urandom_range(0, 1) != 0) ? "W" : "E");
    stat = ($urandom_range(0, 3) == 0) ? "" : (($urandom_range(0, 1) != 0) ? "A" : "V");
    s = $sformatf("GPRMC,%s,%s,%s,%s,%s,%s,%s,%s,%s,,*%02X",
                  rand_number(6, $urandom_range(0, 6)), stat,
                  rand_number(4, $urandom_range(0, 6)), hemi_ns,
                  rand_number(5, $urandom_range(0, 6)), hemi_ew,
                  rand_number($urandom_range(1, 4), $urandom_range(0, 3)),
                  rand_number($urandom_range(1, 3), $urandom_range(0, 5)),
                  rand_digits(6), $urandom_range(0, 255));
    return s;
  endfunction

  // Input driver: changes at the falling edge, holds until the transaction is taken.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !byte_taken) begin
        // hold the current transaction
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        rmc_byte_t b;
        b = pending_bytes.pop_front();
        in_valid <= 1'b1;
        in_char_byte <= b.chr;
        in_end_of_sentence <= b.last;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the parser backs up.
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && bytes_taken >= 300) begin
        hold_done <= 1;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  // Input monitor feeding the predictor.
  always @(posedge clk) begin
    byte_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      track_rmc_char(in_char_byte, in_end_of_sentence);
      bytes_taken <= bytes_taken + 1;
    end
  end

  // Output monitor: each transaction is checked against the oldest expected fix.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      rmc_fix_t got, want;
      got = '{out_utc_time_scaled, out_fix_status, out_latitude_e7, out_longitude_e7,
              out_speed_kmh_scaled, out_course_scaled, out_fields_seen};
      if (expected_fixes.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected fix %p", got);
      end else begin
        want = expected_fixes.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("fix mismatch: expected %p got %p", want, got);
        end
      end
      fixes_checked <= fixes_checked + 1;
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d fixes outstanding", expected_fixes.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int drain;
    clear_sentence();
    // Directed: no commas, signed field alone, end marker on the ninth comma,
    // bytes after the ninth comma, and extreme byte values.
    push_text("x");
    push_text("-5,A");
    push_text(",,,,,,,,,");
    push_text(",,,,,,,,,,zz");
    push_raw(8'hFF, 1'b0);
    push_raw(8'h00, 1'b0);
    push_raw(8'h80, 1'b1);
    // Random part: mostly well-formed sentences, some cut short, some noise.
    while (pending_bytes.size() < 1600) begin
      int r;
      string s;
      r = $urandom_range(0, 9);
      s = build_sentence();
      if (r < 7) begin
        push_text(s);
      end else if (r < 9) begin
        push_text(s.substr(0, $urandom_range(0, s.len() - 1)));
      end else begin
        s = "";
        repeat ($urandom_range(1, 10)) s = {s, string'(8'($urandom_range(0, 255)))};
        push_text(s);
      end
      sentences_built++;
    end
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_fixes.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 40) begin
      @(posedge clk);
      drain++;
    end
    if (expected_fixes.size() != 0) mismatches = mismatches + expected_fixes.size();
    $display("Sent %0d characters in %0d sentences or fragments; %0d fixes checked.",
             bytes_taken, sentences_built + 5, fixes_checked);
    $display("Covered saturation, signs, hemispheres, empty and truncated fields, back-pressure.");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
